/* sv/sector_cache_lru_directory_top_defines.svh */
// Assertion helpers used by the directory RTL.
`ifndef SECTOR_CACHE_LRU_DIRECTORY_TOP_DEFINES_SVH
`define SECTOR_CACHE_LRU_DIRECTORY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCLD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCLD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/scld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types and constants of the sector cache LRU directory.
// ----------------------------------------------------------------------------
package scld_pkg;

    localparam int SCLD_ENTRIES     = 64;
    localparam int SCLD_SECTOR_BITS = 32;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VICTIM,
        ST_RESULT,
        ST_FLUSH_RD,
        ST_FLUSH_CHK,
        ST_FLUSH_NONE
    } t_state;

endpackage

/* sv/sector_cache_lru_directory_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_lru_directory_top
// Directory and true-LRU replacement of a fully associative write-back
// sector cache.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue port: a word {cmd, sector} is taken when
//   i_push is high and o_full is low. Results leave through a queue port:
//   the oldest result sits on the o_ ports while o_empty is low and is taken
//   when i_pop is high. A two-entry queue on each side decouples the engine.
//   Read/write: one result, after a tag scan of one slot per cycle through
//   the single tag RAM read port.
//   Flush: the recency order is rotated once, each slot read and then
//   checked, one result per dirty slot oldest first, or one empty result
//   with last set when nothing is dirty.
//   Unused command codes are dropped without a result.
//   Reset clears all valid and dirty bits and sets the recency order to
//   slot number order; no clearing pass is needed.
//   When the receiver stops popping, the result queue fills, the engine
//   holds its result, and the request queue then raises o_full.
// ----------------------------------------------------------------------------
module sector_cache_lru_directory_top import scld_pkg::*; #(
    parameter int ENTRIES     = SCLD_ENTRIES,
    parameter int SECTOR_BITS = SCLD_SECTOR_BITS,
    localparam int SW         = $clog2(ENTRIES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [1:0]             i_cmd,
    input  logic [SECTOR_BITS-1:0] i_sector,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [SW-1:0]          o_slot,
    output logic                   o_hit,
    output logic                   o_fill_needed,
    output logic                   o_writeback,
    output logic [SECTOR_BITS-1:0] o_writeback_sector,
    output logic                   o_last
);
    localparam int RW = SW + SECTOR_BITS + 4;

    t_req                   req;
    logic [SECTOR_BITS-1:0] req_sector;
    logic                   req_ready;
    logic                   res_push;
    logic                   res_full;
    logic [SW-1:0]          res_slot;
    logic                   res_hit;
    logic                   res_fill;
    logic                   res_wb;
    logic [SECTOR_BITS-1:0] res_wsec;
    logic                   res_last;

    scld_front #(.SECTOR_BITS(SECTOR_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_cmd       (i_cmd),
        .i_sector    (i_sector),
        .o_full      (o_full),
        .o_req       (req),
        .o_sector    (req_sector),
        .i_req_ready (req_ready)
    );

    scld_back #(.ENTRIES(ENTRIES), .SECTOR_BITS(SECTOR_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_sector    (req_sector),
        .o_req_ready (req_ready),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res_slot  (res_slot),
        .o_res_hit   (res_hit),
        .o_res_fill  (res_fill),
        .o_res_wb    (res_wb),
        .o_res_wsec  (res_wsec),
        .o_res_last  (res_last)
    );

    scld_queue #(.W(RW)) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_slot, res_hit, res_fill, res_wb, res_wsec, res_last}),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  ({o_slot, o_hit, o_fill_needed, o_writeback, o_writeback_sector, o_last})
    );
endmodule

/* sv/scld_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_queue
// Two-entry FIFO used on both sides of the directory engine.
// ----------------------------------------------------------------------------
module scld_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_data;
    end
endmodule

/* sv/scld_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_front
// Request queue and command decode; unused command codes are dropped here.
// ----------------------------------------------------------------------------
module scld_front import scld_pkg::*; #(
    parameter int SECTOR_BITS = SCLD_SECTOR_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [1:0]             i_cmd,
    input  logic [SECTOR_BITS-1:0] i_sector,
    output logic                   o_full,
    output t_req                   o_req,
    output logic [SECTOR_BITS-1:0] o_sector,
    input  logic                   i_req_ready
);
    logic [SECTOR_BITS+1:0] q_data;
    logic                   q_empty;
    logic                   q_pop;
    logic [1:0]             q_cmd;
    logic                   drop;

    scld_queue #(.W(SECTOR_BITS + 2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({i_cmd, i_sector}),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign q_cmd    = q_data[SECTOR_BITS+1:SECTOR_BITS];
    assign o_sector = q_data[SECTOR_BITS-1:0];

    always_comb begin
        o_req.valid = 1'b0;
        o_req.op    = OP_READ;
        drop        = 1'b0;
        if (!q_empty) begin
            unique case (q_cmd)
                CMD_READ: begin
                    o_req.valid = 1'b1;
                    o_req.op    = OP_READ;
                end
                CMD_WRITE: begin
                    o_req.valid = 1'b1;
                    o_req.op    = OP_WRITE;
                end
                CMD_FLUSH: begin
                    o_req.valid = 1'b1;
                    o_req.op    = OP_FLUSH;
                end
                default: drop = 1'b1;
            endcase
        end
    end

    assign q_pop = drop || (o_req.valid && i_req_ready);
endmodule

/* sv/scld_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_back
// Directory engine: tag scan, LRU promote, victim pick and dirty flush.
// ----------------------------------------------------------------------------
`include "sector_cache_lru_directory_top_defines.svh"

module scld_back import scld_pkg::*; #(
    parameter int ENTRIES     = SCLD_ENTRIES,
    parameter int SECTOR_BITS = SCLD_SECTOR_BITS,
    localparam int SW         = $clog2(ENTRIES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_req                   i_req,
    input  logic [SECTOR_BITS-1:0] i_sector,
    output logic                   o_req_ready,
    output logic                   o_res_push,
    input  logic                   i_res_full,
    output logic [SW-1:0]          o_res_slot,
    output logic                   o_res_hit,
    output logic                   o_res_fill,
    output logic                   o_res_wb,
    output logic [SECTOR_BITS-1:0] o_res_wsec,
    output logic                   o_res_last
);
    localparam int CW = SW + 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [ENTRIES-1:0]     r_valid;
    logic [ENTRIES-1:0]     r_dirty;
    logic [SW-1:0]          r_order [ENTRIES];
    logic [SECTOR_BITS-1:0] r_tag   [ENTRIES];
    logic [SECTOR_BITS-1:0] r_tag_q;
    t_op                    r_op;
    logic [SECTOR_BITS-1:0] r_sector;
    logic [CW-1:0]          r_addr;
    logic [SW-1:0]          r_q_slot;
    logic                   r_q_v;
    logic [SW-1:0]          r_res_slot;
    logic                   r_res_hit;

    logic                   rd_en;
    logic [SW-1:0]          rd_addr;
    logic                   tag_we;
    logic                   tag_match;
    logic                   scan_end;
    logic [SW-1:0]          head;
    logic [ENTRIES-1:0]     vd;
    logic                   flush_hit;
    logic                   flush_last;
    logic [SW-1:0]          pos;
    logic [SW-1:0]          ppos;

    assign head       = r_order[0];
    assign vd         = r_valid & r_dirty;
    assign tag_match  = r_q_v && r_valid[r_q_slot] && (r_tag_q == r_sector);
    assign scan_end   = r_q_v && (r_q_slot == SW'(ENTRIES - 1));
    assign flush_hit  = vd[head];
    assign flush_last = ((vd & ~(ENTRIES'(1) << head)) == '0);
    assign tag_we     = (r_state == ST_RESULT) && !i_res_full && !r_res_hit;

    // recency position of the slot being promoted
    always_comb begin
        pos = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_order[i] == r_res_slot) pos = pos | SW'(i);
        end
    end
    // a miss always takes the head: invalid slots never leave the front
    assign ppos = r_res_hit ? pos : '0;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head;
        unique case (r_state)
            ST_SCAN: begin
                rd_en   = (r_addr < CW'(ENTRIES));
                rd_addr = r_addr[SW-1:0];
            end
            ST_VICTIM, ST_FLUSH_RD: rd_en = 1'b1;
            default: rd_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.op == OP_FLUSH)
                        n_state = (vd == '0) ? ST_FLUSH_NONE : ST_FLUSH_RD;
                    else
                        n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tag_match)     n_state = ST_RESULT;
                else if (scan_end) n_state = ST_VICTIM;
            end
            ST_VICTIM:   n_state = ST_RESULT;
            ST_RESULT:   if (!i_res_full) n_state = ST_IDLE;
            ST_FLUSH_RD: n_state = ST_FLUSH_CHK;
            ST_FLUSH_CHK: begin
                if (!(flush_hit && i_res_full))
                    n_state = (r_addr == CW'(ENTRIES - 1)) ? ST_IDLE : ST_FLUSH_RD;
            end
            ST_FLUSH_NONE: if (!i_res_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_res_push  = 1'b0;
        o_res_slot  = '0;
        o_res_hit   = 1'b0;
        o_res_fill  = 1'b0;
        o_res_wb    = 1'b0;
        o_res_wsec  = '0;
        o_res_last  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_req_ready = 1'b1;
            ST_RESULT: begin
                o_res_push = !i_res_full;
                o_res_slot = r_res_slot;
                o_res_hit  = r_res_hit;
                o_res_fill = !r_res_hit && (r_op == OP_READ);
                o_res_wb   = !r_res_hit && vd[r_res_slot];
                o_res_wsec = o_res_wb ? r_tag_q : '0;
                o_res_last = 1'b1;
            end
            ST_FLUSH_CHK: begin
                o_res_push = flush_hit && !i_res_full;
                o_res_slot = head;
                o_res_wb   = 1'b1;
                o_res_wsec = r_tag_q;
                o_res_last = flush_last;
            end
            ST_FLUSH_NONE: begin
                o_res_push = !i_res_full;
                o_res_last = 1'b1;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_addr  <= '0;
            r_q_v   <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) r_order[i] <= SW'(i);
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_addr <= '0;
                    r_q_v  <= 1'b0;
                    if (i_req.valid) begin
                        r_op     <= i_req.op;
                        r_sector <= i_sector;
                    end
                end
                ST_SCAN: begin
                    r_q_v    <= rd_en;
                    r_q_slot <= r_addr[SW-1:0];
                    if (rd_en) r_addr <= r_addr + CW'(1);
                    if (tag_match) begin
                        r_res_slot <= r_q_slot;
                        r_res_hit  <= 1'b1;
                    end else if (scan_end) begin
                        r_res_slot <= head;
                        r_res_hit  <= 1'b0;
                    end
                end
                ST_RESULT: begin
                    if (!i_res_full) begin
                        for (int i = 0; i < ENTRIES - 1; i++) begin
                            if (SW'(i) >= ppos) r_order[i] <= r_order[i+1];
                        end
                        r_order[ENTRIES-1]  <= r_res_slot;
                        r_valid[r_res_slot] <= 1'b1;
                        if (!r_res_hit)
                            r_dirty[r_res_slot] <= (r_op == OP_WRITE);
                        else if (r_op == OP_WRITE)
                            r_dirty[r_res_slot] <= 1'b1;
                    end
                end
                ST_FLUSH_CHK: begin
                    if (!(flush_hit && i_res_full)) begin
                        if (flush_hit) r_dirty[head] <= 1'b0;
                        // rotate; a full pass restores the recency order
                        for (int i = 0; i < ENTRIES - 1; i++) r_order[i] <= r_order[i+1];
                        r_order[ENTRIES-1] <= head;
                        r_addr <= r_addr + CW'(1);
                    end
                end
                default: r_q_v <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag[r_res_slot] <= r_sector;
        if (rd_en)  r_tag_q <= r_tag[rd_addr];
    end

    `SCLD_ASSERT_IMP(a_hit_no_fill, i_clk, i_rst_n, o_res_push && o_res_hit, !o_res_fill && !o_res_wb, "hit result asks for fill or writeback")
    `SCLD_ASSERT_NXT(a_valid_sticky, i_clk, i_rst_n, 1'b1, (r_valid & $past(r_valid)) == $past(r_valid), "valid slot lost")
    `SCLD_ASSERT_IMP(a_flush_wb, i_clk, i_rst_n, o_res_push && (r_state == ST_FLUSH_CHK), o_res_wb && r_valid[o_res_slot], "flush result without valid writeback")
    `SCLD_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full, "result pushed into full queue")
endmodule
